// ===== design/xorshift64star_range_generator_unit_macros.svh =====
// assertion macros used by the generator top level
`ifndef XORSHIFT64STAR_RANGE_GENERATOR_UNIT_MACROS_SVH
`define XORSHIFT64STAR_RANGE_GENERATOR_UNIT_MACROS_SVH

// condition that holds at every clock edge outside reset
`define XRG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that holds in the same cycle as its antecedent
`define XRG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/xrg_pkg.sv =====
// shared types, constants and helpers of the xorshift64* range generator
package xrg_pkg;

  localparam logic [63:0] SEED_DEFAULT = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SCRAMBLE_MUL = 64'd2685821657736338717;
  localparam int SHIFT_A    = 12;
  localparam int SHIFT_B    = 25;
  localparam int SHIFT_C    = 27;
  localparam int FRAC_SHIFT = 11;

  // request codes
  localparam logic [2:0] FUNC_RAW    = 3'd0;
  localparam logic [2:0] FUNC_RANGE  = 3'd1;
  localparam logic [2:0] FUNC_FRAC   = 3'd2;
  localparam logic [2:0] FUNC_CHANCE = 3'd3;
  localparam logic [2:0] FUNC_PICK   = 3'd4;
  localparam logic [2:0] FUNC_LOAD   = 3'd5;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // sequencing of the back end
  localparam int MUL_STEPS = 4;
  localparam int DIV_STEPS = 64;
  localparam int STEP_CW   = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        [2:0]  func;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic        [53:0] probability;
    logic signed [31:0] item_count;
    logic        [63:0] new_state;
  } req_t;

  typedef struct packed {
    logic        [63:0] raw_value;
    logic signed [31:0] bounded_value;
    logic        [52:0] fraction_value;
    logic               hit;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_RAW,
    OP_RANGE,
    OP_CHANCE,
    OP_EMPTY,
    OP_LOAD,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] lo;
    logic [32:0] span;
    logic [53:0] prob;
    logic [63:0] seed;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // one xorshift step with the 12/25/27 triple
  function automatic logic [63:0] xorshift_step(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x >> SHIFT_A);
    x = x ^ (x << SHIFT_B);
    x = x ^ (x >> SHIFT_C);
    return x;
  endfunction

endpackage

// ===== design/xorshift64star_range_generator_unit.sv =====
// top level of the xorshift64* range generator
// A 64-bit xorshift64* generator (shifts 12/25/27, fixed scramble multiplier)
// that answers each request transaction with exactly one response
// transaction. Requests pass through a registered front end and a two-entry
// command queue, so new requests are taken while the back end works and while
// a finished response waits for the consumer. In the back end, raw, fraction
// and chance requests go through the state update, the shared 32x32
// multiplier steps that build the low 64 bits of the scramble product and the
// result write; range and pick requests then add the bit-serial remainder of
// the raw value by the span, and that remainder loop sets the sustained rate.
// Load, empty pick and unused codes respond straight from the idle state. The
// back end takes a new command only while idle with no response waiting. The
// state resets to 0x9E3779B97F4A7C15.
`include "xorshift64star_range_generator_unit_macros.svh"

module xorshift64star_range_generator_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  xrg_pkg::req_t req,
  output logic          rsp_valid,
  output xrg_pkg::rsp_t rsp,
  input  logic          rsp_stall
);
  import xrg_pkg::*;

  // front end to queue
  logic          front_valid;
  logic          front_stall;
  cmd_t          front_cmd;

  // queue to back end
  logic          back_valid;
  logic          back_stall;
  cmd_t          back_cmd;

  queue_status_t q_status;

  // classify requests, work out range bounds and spans
  xrg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_stall (front_stall)
  );

  // lets the front keep taking transactions while the back end is busy
  xrg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_cmd    (back_cmd),
    .pop_stall  (back_stall),
    .status     (q_status)
  );

  // generator state, multiplier, serial remainder and response register
  xrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd       (back_cmd),
    .cmd_stall (back_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_stall (rsp_stall)
  );

  // queue can never claim to be both full and empty
  `XRG_ASSERT_ALWAYS(a_queue_status, !(q_status.full && q_status.empty), "queue full and empty")

  // fraction is always the top bits of the raw output
  `XRG_ASSERT_IMPLY(a_frac_match, rsp_valid, rsp.fraction_value == rsp.raw_value[63:FRAC_SHIFT], "fraction mismatch")

  // a chance hit only comes from a chance transaction, which has no bounded value
  `XRG_ASSERT_IMPLY(a_hit_only_chance, rsp_valid && rsp.hit, rsp.bounded_value == 32'sd0, "hit with bounded value")

endmodule

// ===== design/xrg_front.sv =====
// front end: takes requests, sorts them into commands and works out range spans
module xrg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  xrg_pkg::req_t req,
  output logic          cmd_valid,
  output xrg_pkg::cmd_t cmd,
  input  logic          cmd_stall
);
  import xrg_pkg::*;

  logic        take;
  logic        swap;
  logic [31:0] lo_sel;
  logic [31:0] hi_sel;
  logic [32:0] range_span;
  logic        pick_ok;
  cmd_t        cmd_next;

  assign req_stall = cmd_valid && cmd_stall;
  assign take      = req_valid && !req_stall;

  always_comb begin
    swap       = $signed(req.high_bound) < $signed(req.low_bound);
    lo_sel     = swap ? req.high_bound : req.low_bound;
    hi_sel     = swap ? req.low_bound : req.high_bound;
    // difference is never negative, at most 2^32 - 1, so the span is at most 2^32
    range_span = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel} + 33'd1;
    pick_ok    = !req.item_count[31] && (req.item_count != 32'sd0);

    cmd_next      = '0;
    cmd_next.op   = OP_NOP;
    cmd_next.prob = req.probability;
    cmd_next.seed = req.new_state;
    case (req.func)
      FUNC_RAW, FUNC_FRAC: begin
        cmd_next.op = OP_RAW;
      end
      FUNC_RANGE: begin
        cmd_next.op   = OP_RANGE;
        cmd_next.lo   = lo_sel;
        cmd_next.span = range_span;
      end
      FUNC_CHANCE: begin
        cmd_next.op = OP_CHANCE;
      end
      FUNC_PICK: begin
        if (pick_ok) begin
          cmd_next.op   = OP_RANGE;
          cmd_next.lo   = 32'd0;
          cmd_next.span = {1'b0, req.item_count};
        end else begin
          cmd_next.op = OP_EMPTY;
        end
      end
      FUNC_LOAD: begin
        cmd_next.op = OP_LOAD;
      end
      default: begin
        cmd_next.op = OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== design/xrg_queue.sv =====
// short command queue that decouples the front end from the back end
module xrg_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_stall,
  input  xrg_pkg::cmd_t          push_cmd,
  output logic                   pop_valid,
  output xrg_pkg::cmd_t          pop_cmd,
  input  logic                   pop_stall,
  output xrg_pkg::queue_status_t status
);
  import xrg_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                push;
  logic                pop;

  assign status.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign push_stall   = status.full;
  assign pop_valid    = !status.empty;
  assign pop_cmd      = entries[rd_ptr];
  assign push         = push_valid && !push_stall;
  assign pop          = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== design/xrg_back.sv =====
// back end: state update, split 64-bit scramble multiply and serial remainder
module xrg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  xrg_pkg::cmd_t cmd,
  output logic          cmd_stall,
  output logic          rsp_valid,
  output xrg_pkg::rsp_t rsp,
  input  logic          rsp_stall
);
  import xrg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t             st;
  logic [63:0]        gen_state;
  op_t                op;
  logic [31:0]        lo;
  logic [32:0]        span;
  logic [53:0]        prob;
  logic [STEP_CW-1:0] cnt;
  logic [63:0]        prod;
  logic [63:0]        acc;
  logic [63:0]        dq;
  logic [32:0]        rem;

  logic               take;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        raw_fin;
  logic [33:0]        trial;
  logic [33:0]        trial_sub;

  assign cmd_stall = !((st == ST_IDLE) && !rsp_valid);
  assign take      = cmd_valid && !cmd_stall;

  // low 64 bits of state times multiplier from three 32x32 partial products
  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        mul_a = gen_state[31:0];
        mul_b = SCRAMBLE_MUL[31:0];
      end
      2'd1: begin
        mul_a = gen_state[31:0];
        mul_b = SCRAMBLE_MUL[63:32];
      end
      default: begin
        mul_a = gen_state[63:32];
        mul_b = SCRAMBLE_MUL[31:0];
      end
    endcase
    raw_fin   = {acc[63:32] + prod[31:0], acc[31:0]};
    trial     = {rem, dq[63]};
    trial_sub = trial - {1'b0, span};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      gen_state <= SEED_DEFAULT;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (take) begin
            case (cmd.op)
              OP_RAW, OP_RANGE, OP_CHANCE: begin
                gen_state <= xorshift_step(gen_state);
                cnt       <= '0;
                st        <= ST_MUL;
              end
              OP_LOAD: begin
                if (cmd.seed != 64'd0) begin
                  gen_state <= cmd.seed;
                end
                rsp_valid <= 1'b1;
              end
              default: begin
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (cnt[1:0] == 2'(MUL_STEPS - 1)) begin
            cnt <= '0;
            st  <= (op == OP_RANGE) ? ST_DIV : ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt == STEP_CW'(DIV_STEPS - 1)) begin
            st <= ST_DONE;
          end
          cnt <= cnt + 1'b1;
        end
        ST_DONE: begin
          rsp_valid <= 1'b1;
          st        <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        if (take) begin
          op                 <= cmd.op;
          lo                 <= cmd.lo;
          span               <= cmd.span;
          prob               <= cmd.prob;
          rsp.raw_value      <= '0;
          rsp.bounded_value  <= (cmd.op == OP_EMPTY) ? -32'sd1 : 32'sd0;
          rsp.fraction_value <= '0;
          rsp.hit            <= 1'b0;
        end
      end
      ST_MUL: begin
        if (cnt[1:0] != 2'(MUL_STEPS - 1)) begin
          prod <= {32'd0, mul_a} * {32'd0, mul_b};
        end
        if (cnt[1:0] == 2'd1) begin
          acc <= prod;
        end else if (cnt[1:0] == 2'd2) begin
          acc <= raw_fin;
        end else if (cnt[1:0] == 2'(MUL_STEPS - 1)) begin
          acc <= raw_fin;
          dq  <= raw_fin;
          rem <= '0;
        end
      end
      ST_DIV: begin
        // restoring step, remainder always below the span
        if (!trial_sub[33]) begin
          rem <= trial_sub[32:0];
        end else begin
          rem <= trial[32:0];
        end
        dq <= {dq[62:0], 1'b0};
      end
      ST_DONE: begin
        rsp.raw_value      <= acc;
        rsp.fraction_value <= acc[63:FRAC_SHIFT];
        rsp.bounded_value  <= (op == OP_RANGE) ? lo + rem[31:0] : 32'd0;
        rsp.hit            <= (op == OP_CHANCE) && ({1'b0, acc[63:FRAC_SHIFT]} < prob);
      end
      default: begin
      end
    endcase
  end

endmodule
